[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL that checks itself.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/fmbs_pkg.sv]
// ---------------------------------------------------------------------------
// fmbs_pkg
// Types and constants for the FM-index backward search block.
// ---------------------------------------------------------------------------
package fmbs_pkg;

  localparam int OCC_DEPTH_DEF = 4096;

  localparam int BOUND_W   = 12;
  localparam int CNT_W     = 8;
  localparam int SYM_W     = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [SYM_W-1:0] END_SYMBOL = 3'd7;
  localparam logic             ACT_WRITE  = 1'b0;
  localparam logic             ACT_QUERY  = 1'b1;

  localparam logic [CNT_W-1:0] MAX_QUERY_LEN_RST = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_C   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_G   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_T   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUERY = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_HIGH,
    ST_FINISH
  } fmbs_state_t;

  typedef struct packed {
    logic               en;
    logic [SYM_W-1:0]   sym;
    logic [BOUND_W-1:0] idx;
    logic [BOUND_W-1:0] val;
  } occ_wr_t;

  typedef struct packed {
    logic               en;
    logic [1:0]         sym;
    logic [BOUND_W-1:0] pos;
  } occ_rd_t;

endpackage

[rtl/core/fmbs_occ_unit.sv]
// ---------------------------------------------------------------------------
// fmbs_occ_unit
// Occurrence table RAM (four tables of OCC_DEPTH entries) with one write
// port, one registered read port and the shared saturating bound adder.
// ---------------------------------------------------------------------------
module fmbs_occ_unit #(
  parameter int OCC_DEPTH = fmbs_pkg::OCC_DEPTH_DEF
) (
  input  logic                             clk,
  input  fmbs_pkg::occ_wr_t                wr,
  input  fmbs_pkg::occ_rd_t                rd,
  input  logic [fmbs_pkg::BOUND_W-1:0]     base_count,
  output logic [fmbs_pkg::BOUND_W-1:0]     bound_sum
);

  localparam int AW        = $clog2(OCC_DEPTH);
  // each table is padded to a power of two so the base select is the top bits
  localparam int MEM_DEPTH = 4 * (2 ** AW);
  localparam int BOUND_MAX = (OCC_DEPTH < 4096) ? OCC_DEPTH - 1 : 4095;
  localparam logic [31:0] DEPTH32 = 32'(OCC_DEPTH);
  localparam logic [AW-1:0] POS_MAX = AW'(OCC_DEPTH - 1);
  localparam logic [fmbs_pkg::BOUND_W:0] SUM_MAX = (fmbs_pkg::BOUND_W + 1)'(BOUND_MAX);

  logic [fmbs_pkg::BOUND_W-1:0] mem [MEM_DEPTH];
  logic [fmbs_pkg::BOUND_W-1:0] rd_data_r;

  logic              wr_ok;
  logic [AW+1:0]     wr_addr;
  logic [AW-1:0]     rd_pos;
  logic [AW+1:0]     rd_addr;
  logic [fmbs_pkg::BOUND_W:0] raw_sum;

  assign wr_ok   = wr.en && !wr.sym[2] && (32'(wr.idx) < DEPTH32);
  assign wr_addr = {wr.sym[1:0], AW'(wr.idx)};
  assign rd_pos  = (32'(rd.pos) >= DEPTH32) ? POS_MAX : AW'(rd.pos);
  assign rd_addr = {rd.sym, rd_pos};

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.val;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign raw_sum   = {1'b0, base_count} + {1'b0, rd_data_r};
  assign bound_sum = (raw_sum > SUM_MAX) ? fmbs_pkg::BOUND_W'(BOUND_MAX)
                                         : raw_sum[fmbs_pkg::BOUND_W-1:0];

endmodule

[rtl/core/fm_index_backward_search.sv]
// ---------------------------------------------------------------------------
// fm_index_backward_search
// FM-index backward search over A/C/G/T with loadable occurrence tables.
// ---------------------------------------------------------------------------
// A write transaction (action 0) stores one occurrence entry; symbols 4..7
// and indices past the table are dropped. A query with symbol 7, with the
// query at its maximum length, or with symbol 4..6 reports at once. A query
// with a base symbol passes ST_READ_HIGH and ST_FINISH: the occurrence RAM
// has a single registered read port, so the lower and upper bound reads go
// one after the other through it and through one saturating adder. The result
// is held in an output register; a new transaction is taken in ST_IDLE once
// that register is free or being drained. The occurrence RAM is not reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fm_index_backward_search #(
  parameter int OCC_DEPTH = fmbs_pkg::OCC_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [fmbs_pkg::SYM_W-1:0]         in_symbol,
  input  logic [fmbs_pkg::BOUND_W-1:0]       in_occ_index,
  input  logic [fmbs_pkg::BOUND_W-1:0]       in_occ_value,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fmbs_pkg::BOUND_W-1:0]       out_low_bound,
  output logic [fmbs_pkg::BOUND_W-1:0]       out_high_bound,
  output logic                               out_query_done,
  output logic                               out_bad_symbol,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fmbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fmbs_pkg::BOUND_W-1:0]       cfg_data
);

  localparam int BW = fmbs_pkg::BOUND_W;
  localparam int CW = fmbs_pkg::CNT_W;

  fmbs_pkg::fmbs_state_t state_r, state_nxt;

  logic [BW-1:0] count_a_r, count_c_r, count_g_r, count_t_r, text_len_r;
  logic [CW-1:0] max_query_r;

  logic [BW-1:0] low_r, low_nxt;
  logic [BW-1:0] high_r, high_nxt;
  logic [CW-1:0] sym_cnt_r, sym_cnt_nxt;
  logic [1:0]    sym_r, sym_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] out_low_r, out_low_nxt;
  logic [BW-1:0] out_high_r, out_high_nxt;
  logic          out_done_r, out_done_nxt;
  logic          out_bad_r, out_bad_nxt;

  fmbs_pkg::occ_wr_t occ_wr;
  fmbs_pkg::occ_rd_t occ_rd;
  logic [BW-1:0]     base_count;
  logic [BW-1:0]     bound_sum;
  logic              in_fire;
  logic              query_end;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == fmbs_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign query_end = (in_symbol == fmbs_pkg::END_SYMBOL) || (sym_cnt_r >= max_query_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      count_c_r   <= '0;
      count_g_r   <= '0;
      count_t_r   <= '0;
      text_len_r  <= '0;
      max_query_r <= fmbs_pkg::MAX_QUERY_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fmbs_pkg::CFG_COUNT_A:   count_a_r   <= cfg_data;
        fmbs_pkg::CFG_COUNT_C:   count_c_r   <= cfg_data;
        fmbs_pkg::CFG_COUNT_G:   count_g_r   <= cfg_data;
        fmbs_pkg::CFG_COUNT_T:   count_t_r   <= cfg_data;
        fmbs_pkg::CFG_TEXT_LEN:  text_len_r  <= cfg_data;
        fmbs_pkg::CFG_MAX_QUERY: max_query_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sym_r)
      2'd0:    base_count = count_a_r;
      2'd1:    base_count = count_c_r;
      2'd2:    base_count = count_g_r;
      default: base_count = count_t_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmbs_pkg::ST_IDLE;
      low_r       <= '0;
      high_r      <= '0;
      sym_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      sym_cnt_r   <= sym_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
    out_done_r <= out_done_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    sym_cnt_nxt   = sym_cnt_r;
    sym_nxt       = sym_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_low_nxt   = out_low_r;
    out_high_nxt  = out_high_r;
    out_done_nxt  = out_done_r;
    out_bad_nxt   = out_bad_r;

    occ_wr.en  = 1'b0;
    occ_wr.sym = in_symbol;
    occ_wr.idx = in_occ_index;
    occ_wr.val = in_occ_value;
    occ_rd.en  = 1'b0;
    occ_rd.sym = in_symbol[1:0];
    occ_rd.pos = low_r;

    case (state_r)
      fmbs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_action == fmbs_pkg::ACT_WRITE) begin
            occ_wr.en = 1'b1;
          end else if (query_end) begin
            out_valid_nxt = 1'b1;
            out_low_nxt   = low_r;
            out_high_nxt  = high_r;
            out_done_nxt  = 1'b1;
            out_bad_nxt   = 1'b0;
            low_nxt       = '0;
            high_nxt      = text_len_r;
            sym_cnt_nxt   = '0;
          end else if (in_symbol[2]) begin
            out_valid_nxt = 1'b1;
            out_low_nxt   = low_r;
            out_high_nxt  = high_r;
            out_done_nxt  = 1'b0;
            out_bad_nxt   = 1'b1;
          end else begin
            occ_rd.en = 1'b1;
            sym_nxt   = in_symbol[1:0];
            state_nxt = fmbs_pkg::ST_READ_HIGH;
          end
        end
      end
      fmbs_pkg::ST_READ_HIGH: begin
        low_nxt    = bound_sum;
        occ_rd.en  = 1'b1;
        occ_rd.sym = sym_r;
        occ_rd.pos = high_r;
        state_nxt  = fmbs_pkg::ST_FINISH;
      end
      fmbs_pkg::ST_FINISH: begin
        high_nxt      = bound_sum;
        sym_cnt_nxt   = sym_cnt_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_low_nxt   = low_r;
        out_high_nxt  = bound_sum;
        out_done_nxt  = 1'b0;
        out_bad_nxt   = 1'b0;
        state_nxt     = fmbs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fmbs_pkg::ST_IDLE;
      end
    endcase
  end

  fmbs_occ_unit #(
    .OCC_DEPTH (OCC_DEPTH)
  ) u_occ (
    .clk        (clk),
    .wr         (occ_wr),
    .rd         (occ_rd),
    .base_count (base_count),
    .bound_sum  (bound_sum)
  );

  assign out_valid      = out_valid_r;
  assign out_low_bound  = out_low_r;
  assign out_high_bound = out_high_r;
  assign out_query_done = out_done_r;
  assign out_bad_symbol = out_bad_r;

  `ASSERT_SAME(a_busy_not_ready, state_r != fmbs_pkg::ST_IDLE, !in_ready, "ready while busy")
  `ASSERT_NEXT(a_read_then_finish, state_r == fmbs_pkg::ST_READ_HIGH, state_r == fmbs_pkg::ST_FINISH, "second read not followed by finish")
  `ASSERT_NEXT(a_finish_reports, state_r == fmbs_pkg::ST_FINISH, out_valid && !out_query_done && !out_bad_symbol, "finish did not report interval")
  `ASSERT_SAME(a_out_flags_excl, out_valid, !(out_query_done && out_bad_symbol), "done and bad both set")

endmodule

[dv/fm_index_backward_search_chk.sv]
// ---------------------------------------------------------------------------
// fm_index_backward_search_chk
// Watches the query, result and register channels of the backward search
// block. Tracks the occurrence tables, the C counts, the suffix interval and
// the query length, queues the interval report due for every query
// transaction and compares each result against the oldest one, field by
// field. Hands the mismatch count and the number of reports still due to
// the testbench top.
// ---------------------------------------------------------------------------
module fm_index_backward_search_chk #(
  parameter int OCC_DEPTH = fmbs_pkg::OCC_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_action,
  input  logic [fmbs_pkg::SYM_W-1:0]     in_symbol,
  input  logic [fmbs_pkg::BOUND_W-1:0]   in_occ_index,
  input  logic [fmbs_pkg::BOUND_W-1:0]   in_occ_value,

  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [fmbs_pkg::BOUND_W-1:0]   out_low_bound,
  input  logic [fmbs_pkg::BOUND_W-1:0]   out_high_bound,
  input  logic                           out_query_done,
  input  logic                           out_bad_symbol,

  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fmbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fmbs_pkg::BOUND_W-1:0]   cfg_data,

  output int                             errors,
  output int                             pending
);
  import fmbs_pkg::*;

  localparam int BOUND_MAX = (OCC_DEPTH < 4096) ? OCC_DEPTH - 1 : 4095;

  typedef struct packed {
    logic [BOUND_W-1:0] low;
    logic [BOUND_W-1:0] high;
    logic               done;
    logic               bad;
  } interval_rpt_t;

  logic [BOUND_W-1:0] base_count [4];
  logic [BOUND_W-1:0] text_len;
  logic [CNT_W-1:0]   max_len;
  logic [BOUND_W-1:0] low_q;
  logic [BOUND_W-1:0] high_q;
  logic [CNT_W-1:0]   sym_cnt;
  logic [BOUND_W-1:0] occ_tbl [4*OCC_DEPTH];

  interval_rpt_t interval_reports_due [$];
  interval_rpt_t head;
  int            mismatch_count = 0;

  // C[base] + occ[base][pos], read address and sum both saturated
  function automatic logic [BOUND_W-1:0] narrowed_bound(input logic [1:0] base,
                                                        input logic [BOUND_W-1:0] pos);
    int addr;
    int sum;
    addr = (int'(pos) >= OCC_DEPTH) ? OCC_DEPTH - 1 : int'(pos);
    sum  = int'(base_count[base]) + int'(occ_tbl[int'(base) * OCC_DEPTH + addr]);
    if (sum > BOUND_MAX) sum = BOUND_MAX;
    return sum[BOUND_W-1:0];
  endfunction

  task automatic post_report(input interval_rpt_t rpt);
    interval_reports_due.insert(interval_reports_due.size(), rpt);
  endtask

  task automatic apply_search_item(input logic act, input logic [SYM_W-1:0] sym,
                                   input logic [BOUND_W-1:0] idx,
                                   input logic [BOUND_W-1:0] val);
    interval_rpt_t      rpt;
    logic [BOUND_W-1:0] new_low;
    rpt.low  = low_q;
    rpt.high = high_q;
    rpt.done = 1'b0;
    rpt.bad  = 1'b0;
    if (act == ACT_WRITE) begin
      if (!sym[SYM_W-1] && int'(idx) < OCC_DEPTH)
        occ_tbl[int'(sym[1:0]) * OCC_DEPTH + int'(idx)] = val;
    end else if (sym == END_SYMBOL || sym_cnt >= max_len) begin
      rpt.done = 1'b1;
      post_report(rpt);
      low_q   = '0;
      high_q  = text_len;
      sym_cnt = '0;
    end else if (sym[SYM_W-1]) begin
      rpt.bad = 1'b1;
      post_report(rpt);
    end else begin
      new_low  = narrowed_bound(sym[1:0], low_q);
      high_q   = narrowed_bound(sym[1:0], high_q);
      low_q    = new_low;
      sym_cnt  = sym_cnt + 1'b1;
      rpt.low  = low_q;
      rpt.high = high_q;
      post_report(rpt);
    end
  endtask

  task automatic check_field(input string what, input logic [BOUND_W-1:0] want_v,
                             input logic [BOUND_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 4; b++) base_count[b] = '0;
      text_len = '0;
      max_len  = MAX_QUERY_LEN_RST;
      low_q    = '0;
      high_q   = '0;
      sym_cnt  = '0;
      interval_reports_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (interval_reports_due.size() == 0) begin
          $display("%0t: result with no transaction pending: low %0d high %0d done %b bad %b",
                   $time, out_low_bound, out_high_bound, out_query_done, out_bad_symbol);
          mismatch_count++;
        end else begin
          head = interval_reports_due.pop_front();
          check_field("low_bound", head.low, out_low_bound);
          check_field("high_bound", head.high, out_high_bound);
          check_field("query_done", BOUND_W'(head.done), BOUND_W'(out_query_done));
          check_field("bad_symbol", BOUND_W'(head.bad), BOUND_W'(out_bad_symbol));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COUNT_A:   base_count[0] = cfg_data;
          CFG_COUNT_C:   base_count[1] = cfg_data;
          CFG_COUNT_G:   base_count[2] = cfg_data;
          CFG_COUNT_T:   base_count[3] = cfg_data;
          CFG_TEXT_LEN:  text_len = cfg_data;
          CFG_MAX_QUERY: max_len = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        apply_search_item(in_action, in_symbol, in_occ_index, in_occ_value);
    end
    errors  <= mismatch_count;
    pending <= interval_reports_due.size();
  end

endmodule

[dv/fm_index_backward_search_tb.sv]
// ---------------------------------------------------------------------------
// fm_index_backward_search_tb
// Drives the backward search block: a few queries at reset values, a load of
// the low positions and the last position of the four occurrence tables, a
// directed pass over every symbol and the table extremes, then random query
// and table-write traffic under a series of register settings, including
// all-zero and all-max ones. Counts and entries are kept small or at full
// scale so every bound lands on a loaded position. Both channels idle in
// short random bursts until the last stretch of the run.
// ---------------------------------------------------------------------------
module fm_index_backward_search_tb;
  import fmbs_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  // counts up to 31 plus entries up to 32 stay below 64; full scale saturates
  localparam int LOAD_SPAN  = 64;
  localparam int COUNT_SPAN = 31;
  localparam int OCC_SPAN   = 32;

  localparam logic [SYM_W-1:0]     LAST_BASE = 3'd3;
  localparam logic [SYM_W-1:0]     FIRST_BAD = 3'd4;
  localparam logic [SYM_W-1:0]     SYM_A     = 3'd0;
  localparam logic [SYM_W-1:0]     SYM_C     = 3'd1;
  localparam logic [SYM_W-1:0]     SYM_G     = 3'd2;
  localparam logic [SYM_W-1:0]     SYM_T     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [BOUND_W-1:0]   POS_LAST  = BOUND_W'(OCC_DEPTH_DEF - 1);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_action = ACT_WRITE;
  logic [SYM_W-1:0]   in_symbol = '0;
  logic [BOUND_W-1:0] in_occ_index = '0;
  logic [BOUND_W-1:0] in_occ_value = '0;
  logic               out_ready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COUNT_A;
  logic [BOUND_W-1:0] cfg_data = '0;

  logic               in_ready;
  logic               out_valid;
  logic [BOUND_W-1:0] out_low_bound;
  logic [BOUND_W-1:0] out_high_bound;
  logic               out_query_done;
  logic               out_bad_symbol;
  logic               cfg_ready;

  int errors;
  int pending;
  bit calm = 1'b0;
  int stall_left = 0;
  int tick_count = 0;

  always #5 clk = ~clk;

  fm_index_backward_search #(.OCC_DEPTH(OCC_DEPTH_DEF)) uut (.*);

  fm_index_backward_search_chk #(.OCC_DEPTH(OCC_DEPTH_DEF)) chk (.*);

  always @(posedge clk) begin
    tick_count <= tick_count + 1;
    if (tick_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [BOUND_W-1:0] occ_pick();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BOUND_W'($urandom_range(0, OCC_SPAN));
    endcase
  endfunction

  function automatic logic [BOUND_W-1:0] idx_pick();
    case ($urandom_range(0, 15))
      0:       return POS_LAST;
      1:       return BOUND_W'($urandom);
      default: return BOUND_W'($urandom_range(0, LOAD_SPAN - 1));
    endcase
  endfunction

  function automatic logic [BOUND_W-1:0] count_pick();
    if ($urandom_range(0, 7) == 0) return '1;
    return BOUND_W'($urandom_range(0, COUNT_SPAN));
  endfunction

  function automatic logic [BOUND_W-1:0] len_pick();
    if ($urandom_range(0, 3) == 0) return '1;
    return BOUND_W'($urandom_range(0, LOAD_SPAN - 1));
  endfunction

  task automatic send_item(input logic act, input logic [SYM_W-1:0] sym,
                           input logic [BOUND_W-1:0] idx, input logic [BOUND_W-1:0] val);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_symbol    <= sym;
    in_occ_index <= idx;
    in_occ_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_query(input logic [SYM_W-1:0] sym);
    send_item(ACT_QUERY, sym, BOUND_W'($urandom), BOUND_W'($urandom));
  endtask

  // stop sending and wait for every outstanding interval report
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [BOUND_W-1:0] a, input logic [BOUND_W-1:0] c,
                               input logic [BOUND_W-1:0] g, input logic [BOUND_W-1:0] t,
                               input logic [BOUND_W-1:0] len, input logic [BOUND_W-1:0] maxq);
    cfg_put(CFG_COUNT_A, a);
    cfg_put(CFG_COUNT_C, c);
    cfg_put(CFG_COUNT_G, g);
    cfg_put(CFG_COUNT_T, t);
    cfg_put(CFG_TEXT_LEN, len);
    cfg_put(CFG_MAX_QUERY, maxq);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int count, input int write_pct, input int end_pct,
                              input int bad_pct);
    int               roll;
    logic [SYM_W-1:0] sym;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < write_pct) begin
        if ($urandom_range(0, 9) == 0)
          sym = SYM_W'($urandom_range(FIRST_BAD, END_SYMBOL));
        else
          sym = SYM_W'($urandom_range(0, LAST_BASE));
        send_item(ACT_WRITE, sym, idx_pick(), occ_pick());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < end_pct)
          sym = END_SYMBOL;
        else if (roll < end_pct + bad_pct)
          sym = SYM_W'($urandom_range(FIRST_BAD, END_SYMBOL - 1));
        else
          sym = SYM_W'($urandom_range(0, LAST_BASE));
        send_query(sym);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tables are empty: only query ends and bad symbols are legal here
    send_query(END_SYMBOL);
    for (int s = FIRST_BAD; s < END_SYMBOL; s++) send_query(SYM_W'(s));
    settle();

    cfg_put(CFG_SPARE_LO, '1);
    cfg_put(CFG_SPARE_HI, '1);
    load_settings(12'd5, 12'd17, 12'd29, 12'hFFF, 12'hFFF, 12'd255);

    for (int b = 0; b <= LAST_BASE; b++) begin
      for (int p = 0; p < LOAD_SPAN; p++)
        send_item(ACT_WRITE, SYM_W'(b), BOUND_W'(p), occ_pick());
      send_item(ACT_WRITE, SYM_W'(b), POS_LAST, occ_pick());
    end

    for (int s = FIRST_BAD; s <= END_SYMBOL; s++)
      send_item(ACT_WRITE, SYM_W'(s), '0, BOUND_W'($urandom));
    send_item(ACT_WRITE, SYM_A, '0, '0);
    send_item(ACT_WRITE, SYM_A, POS_LAST, '1);
    send_query(END_SYMBOL);
    send_query(SYM_A);
    send_query(SYM_C);
    for (int s = FIRST_BAD; s < END_SYMBOL; s++) send_query(SYM_W'(s));
    send_query(SYM_G);
    send_query(SYM_T);
    send_query(END_SYMBOL);
    settle();

    // all zero; upper bits of the length write must be dropped
    load_settings('0, '0, '0, '0, '0, 12'hF00);
    random_items(200, 10, 5, 10);
    settle();

    load_settings('1, '1, '1, '1, '1, 12'd255);
    random_items(200, 15, 5, 10);
    settle();

    load_settings(count_pick(), count_pick(), count_pick(), count_pick(), len_pick(),
                  BOUND_W'($urandom_range(1, 6)));
    random_items(300, 15, 3, 8);
    settle();

    // one query runs into the length limit
    load_settings(BOUND_W'($urandom_range(0, COUNT_SPAN)), BOUND_W'($urandom_range(0, COUNT_SPAN)),
                  BOUND_W'($urandom_range(0, COUNT_SPAN)), BOUND_W'($urandom_range(0, COUNT_SPAN)),
                  '1, 12'd255);
    random_items(300, 0, 0, 5);
    settle();

    load_settings(count_pick(), count_pick(), count_pick(), count_pick(), len_pick(),
                  BOUND_W'($urandom));
    random_items(300, 10, 4, 8);
    calm <= 1'b1;
    random_items(270, 10, 5, 5);

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/fmbs_pkg.sv
rtl/core/fmbs_occ_unit.sv
rtl/core/fm_index_backward_search.sv
dv/fm_index_backward_search_chk.sv
dv/fm_index_backward_search_tb.sv
